/* design/pts5_pkg.sv */
// Shared types, widths and constants for the type five polar node decoder.
`timescale 1ns / 1ps

package pts5_pkg;

  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int PAIR_W = 2;
  localparam int SUM_W  = 16;
  localparam int VAL_W  = 17;
  localparam int REP_W  = 19;
  localparam int CFG_W  = 8;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 16'sh7FFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 16'sh8000;
  localparam logic signed [VAL_W-1:0] HARD_POS = 17'sd1;
  localparam logic signed [VAL_W-1:0] HARD_NEG = -17'sd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_FPASS,
    ST_GPASS,
    ST_FLIP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                    we;
    logic [LANE_W-1:0]       addr;
    logic signed [SUM_W-1:0] data;
    logic                    clear;
  } mem_wr_t;

endpackage

/* design/pts5_lane_mem.sv */
// Lane accumulator memory: one write port, two registered read ports, per-entry valid bits.
`timescale 1ns / 1ps

module pts5_lane_mem (
  input  logic                                    clk,
  input  logic                                    rst,
  input  pts5_pkg::mem_wr_t                       wr,
  input  logic [pts5_pkg::LANE_W-1:0]             raddr_a,
  input  logic [pts5_pkg::LANE_W-1:0]             raddr_b,
  output logic signed [pts5_pkg::SUM_W-1:0]       rdata_a,
  output logic signed [pts5_pkg::SUM_W-1:0]       rdata_b
);

  logic signed [pts5_pkg::SUM_W-1:0] mem [pts5_pkg::LANES];
  logic [pts5_pkg::LANES-1:0]        valid;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_a <= valid[raddr_a] ? mem[raddr_a] : '0;
    rdata_b <= valid[raddr_b] ? mem[raddr_b] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.clear) begin
      valid <= '0;
    end else if (wr.we) begin
      valid[wr.addr] <= 1'b1;
    end
  end

endmodule

/* design/polar_type_five_node_decoder_unit.sv */
// Top level of the streaming type five polar node decoder.
// Usage: LLRs enter on the input channel (in_valid, in_stall, llr), one per item.
// Item p of a block is added, with saturation, into lane accumulator p mod 8 held
// in a small memory. A block is 8 * block_groups items (0 acts as 1, values
// above MAX_GROUPS act as MAX_GROUPS). The user must write block_groups through
// cfg_write_en / cfg_write_data only while the block is idle; the block does
// not enforce this. Each item is read from memory, then added and written back.
// After the last item of a block, the decoder reads lane pairs twice (min-sum F
// pass, then G pass with SPC minimum search) and applies the parity flip, then
// presents eight result items on the output channel (out_valid, out_stall,
// value, lane, last), one per cycle unless stalled. in_stall is high from the
// accept of an item until it is absorbed, and during the whole decode and
// output phase. A stalled result holds its payload. Synchronous reset clears
// the accumulators, the position and sets block_groups to 1.
`timescale 1ns / 1ps

module polar_type_five_node_decoder_unit #(
  parameter int MAX_GROUPS = 128,
  parameter int LLR_WIDTH  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [pts5_pkg::CFG_W-1:0]            cfg_write_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [LLR_WIDTH-1:0]           llr,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pts5_pkg::VAL_W-1:0]     value,
  output logic [pts5_pkg::LANE_W-1:0]           lane,
  output logic                                  last
);

  localparam int POS_W  = $clog2(pts5_pkg::LANES * MAX_GROUPS + 1);
  localparam int GRP_BW = $clog2(MAX_GROUPS + 1);
  localparam int EG_W   = (GRP_BW > pts5_pkg::CFG_W) ? GRP_BW : pts5_pkg::CFG_W;
  localparam int SX_W   = pts5_pkg::SUM_W + 1;

  pts5_pkg::state_t state, state_next;

  logic [pts5_pkg::CFG_W-1:0]              block_groups;
  logic [POS_W-1:0]                        position;
  logic [2:0]                              cnt;
  logic signed [LLR_WIDTH-1:0]             llr_q;
  logic signed [pts5_pkg::REP_W-1:0]       rep;
  logic signed [pts5_pkg::VAL_W-1:0]       g [4];
  logic [3:0]                              neg;
  logic                                    parity;
  logic [pts5_pkg::VAL_W:0]                best;
  logic [pts5_pkg::PAIR_W-1:0]             best_idx;

  pts5_pkg::mem_wr_t                       mem_wr;
  logic [pts5_pkg::LANE_W-1:0]             raddr_a, raddr_b;
  logic signed [pts5_pkg::SUM_W-1:0]       rdata_a, rdata_b;

  logic [EG_W-1:0]                         bg_ext, eff_groups;
  logic [POS_W-1:0]                        end_pos, position_inc;
  logic                                    block_end;
  logic signed [SX_W-1:0]                  sum_wide;
  logic signed [pts5_pkg::SUM_W-1:0]       sum_sat;
  logic [pts5_pkg::PAIR_W-1:0]             pidx;
  logic [pts5_pkg::SUM_W:0]                mag_a, mag_b, mag_min;
  logic signed [pts5_pkg::REP_W-1:0]       fterm;
  logic signed [pts5_pkg::VAL_W-1:0]       a_ext, b_ext, g_val;
  logic [pts5_pkg::VAL_W:0]                g_mag;

  pts5_lane_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (mem_wr),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Block length and end detection.
  always_comb begin
    bg_ext = EG_W'(block_groups);
    if (bg_ext == '0) begin
      eff_groups = EG_W'(1);
    end else if (bg_ext > EG_W'(MAX_GROUPS)) begin
      eff_groups = EG_W'(MAX_GROUPS);
    end else begin
      eff_groups = bg_ext;
    end
    end_pos      = POS_W'({eff_groups, {pts5_pkg::LANE_W{1'b0}}});
    position_inc = position + POS_W'(1);
    block_end    = (position_inc >= end_pos);
  end

  // Saturating accumulate.
  always_comb begin
    sum_wide = SX_W'(rdata_a) + SX_W'(llr_q);
    if (sum_wide[SX_W-1] != sum_wide[SX_W-2]) begin
      sum_sat = sum_wide[SX_W-1] ? pts5_pkg::SUM_MIN : pts5_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_wide[pts5_pkg::SUM_W-1:0];
    end
  end

  // Min-sum F term and G combination of the pair read in the previous cycle.
  always_comb begin
    pidx    = pts5_pkg::PAIR_W'(cnt - 3'd1);
    a_ext   = pts5_pkg::VAL_W'(rdata_a);
    b_ext   = pts5_pkg::VAL_W'(rdata_b);
    mag_a   = a_ext[pts5_pkg::VAL_W-1] ? pts5_pkg::VAL_W'(-a_ext) : pts5_pkg::VAL_W'(a_ext);
    mag_b   = b_ext[pts5_pkg::VAL_W-1] ? pts5_pkg::VAL_W'(-b_ext) : pts5_pkg::VAL_W'(b_ext);
    mag_min = (mag_a < mag_b) ? mag_a : mag_b;
    if (rdata_a[pts5_pkg::SUM_W-1] != rdata_b[pts5_pkg::SUM_W-1]) begin
      fterm = -pts5_pkg::REP_W'(mag_min);
    end else begin
      fterm = pts5_pkg::REP_W'(mag_min);
    end
    g_val = rep[pts5_pkg::REP_W-1] ? (b_ext - a_ext) : (b_ext + a_ext);
    g_mag = g_val[pts5_pkg::VAL_W-1] ? -(pts5_pkg::VAL_W + 1)'(g_val)
                                     : (pts5_pkg::VAL_W + 1)'(g_val);
  end

  always_comb begin
    state_next = state;
    case (state)
      pts5_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = pts5_pkg::ST_ACC;
        end
      end
      pts5_pkg::ST_ACC: begin
        state_next = block_end ? pts5_pkg::ST_FPASS : pts5_pkg::ST_IDLE;
      end
      pts5_pkg::ST_FPASS: begin
        if (cnt == 3'd4) begin
          state_next = pts5_pkg::ST_GPASS;
        end
      end
      pts5_pkg::ST_GPASS: begin
        if (cnt == 3'd4) begin
          state_next = pts5_pkg::ST_FLIP;
        end
      end
      pts5_pkg::ST_FLIP: begin
        state_next = pts5_pkg::ST_OUT;
      end
      pts5_pkg::ST_OUT: begin
        if (!out_stall && cnt == 3'(pts5_pkg::LANES - 1)) begin
          state_next = pts5_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pts5_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    mem_wr.we    = 1'b0;
    mem_wr.clear = 1'b0;
    mem_wr.addr  = position[pts5_pkg::LANE_W-1:0];
    mem_wr.data  = sum_sat;
    raddr_a      = position[pts5_pkg::LANE_W-1:0];
    raddr_b      = {1'b1, cnt[pts5_pkg::PAIR_W-1:0]};
    case (state)
      pts5_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      pts5_pkg::ST_ACC: begin
        mem_wr.we = 1'b1;
      end
      pts5_pkg::ST_FPASS, pts5_pkg::ST_GPASS: begin
        raddr_a = {1'b0, cnt[pts5_pkg::PAIR_W-1:0]};
      end
      pts5_pkg::ST_FLIP: begin
        mem_wr.clear = 1'b1;
      end
      pts5_pkg::ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    lane = cnt;
    last = (cnt == 3'(pts5_pkg::LANES - 1));
    if (cnt[2]) begin
      value = g[cnt[pts5_pkg::PAIR_W-1:0]];
    end else if (rep[pts5_pkg::REP_W-1] != neg[cnt[pts5_pkg::PAIR_W-1:0]]) begin
      value = pts5_pkg::HARD_NEG;
    end else begin
      value = pts5_pkg::HARD_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pts5_pkg::ST_IDLE;
      block_groups <= pts5_pkg::CFG_W'(1);
      position     <= '0;
      cnt          <= '0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        block_groups <= cfg_write_data;
      end
      case (state)
        pts5_pkg::ST_IDLE: begin
          if (in_valid) begin
            llr_q <= llr;
          end
        end
        pts5_pkg::ST_ACC: begin
          if (block_end) begin
            position <= '0;
            rep      <= '0;
            cnt      <= '0;
          end else begin
            position <= position_inc;
          end
        end
        pts5_pkg::ST_FPASS: begin
          if (cnt != 3'd0) begin
            rep <= rep + fterm;
          end
          if (cnt == 3'd4) begin
            cnt    <= '0;
            parity <= 1'b0;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        pts5_pkg::ST_GPASS: begin
          if (cnt != 3'd0) begin
            g[pidx]   <= g_val;
            neg[pidx] <= g_val[pts5_pkg::VAL_W-1];
            parity    <= parity ^ g_val[pts5_pkg::VAL_W-1];
            if (pidx == '0 || g_mag < best) begin
              best     <= g_mag;
              best_idx <= pidx;
            end
          end
          cnt <= (cnt == 3'd4) ? 3'd0 : cnt + 3'd1;
        end
        pts5_pkg::ST_FLIP: begin
          if (parity) begin
            g[best_idx]   <= -g[best_idx];
            neg[best_idx] <= ~neg[best_idx];
          end
          cnt <= '0;
        end
        pts5_pkg::ST_OUT: begin
          if (!out_stall) begin
            cnt <= cnt + 3'd1;
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

endmodule
